// ----- rtl/sml_pkg.sv -----
// ----------------------------------------------------------------------------
// sml_pkg
// Shared constants and codes for the spin moment learner.
// ----------------------------------------------------------------------------
package sml_pkg;

  localparam int NumBitsDef    = 16;
  localparam int MaxSamplesDef = 1023;

  localparam int ActW   = 2;
  localparam int SampW  = 16;
  localparam int IdxW   = 4;
  localparam int CfgW   = 17;
  localparam int ModelW = 18;
  localparam int SumOW  = 11;
  localparam int CntOW  = 10;
  localparam int FracW  = 16;

  localparam logic [CfgW-1:0] OneQ16 = 17'd65536;
  localparam logic [CfgW-1:0] RateRst = 17'd6554;
  localparam logic [CfgW-1:0] MargRst = 17'd0;

  typedef enum logic [ActW-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_LEARN = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  localparam logic REG_LEARN_RATE  = 1'b0;
  localparam logic REG_CLIP_MARGIN = 1'b1;

endpackage

// ----- rtl/sml_ram.sv -----
// ----------------------------------------------------------------------------
// sml_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sml_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/spin_moment_learner_core.sv -----
// ----------------------------------------------------------------------------
// spin_moment_learner_core
// Spin sums and learned first/second moments over sampled bit vectors.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  input     in         in_valid_i / in_stall_o   action, sample_bits, row, col
//  output    out        out_valid_o / out_stall_i model, sum, count, error
//  config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  Work per beat: clear runs a zero sweep of the sum memory, add does one
//  read-modify-write per entry, learn runs a bit-serial divider per entry.
//  After reset a sweep zeroes both memories; no beat is taken meanwhile.
//  One item at a time: in_stall_o is high while busy.
//  A finished result waits in the output register under out_stall_i.
//
module spin_moment_learner_core
  import sml_pkg::*;
#(
  parameter int NUM_BITS    = NumBitsDef,
  parameter int MAX_SAMPLES = MaxSamplesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ActW-1:0]          action_i,
  input  logic [SampW-1:0]         sample_bits_i,
  input  logic [IdxW-1:0]          row_index_i,
  input  logic [IdxW-1:0]          col_index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ModelW-1:0] model_value_o,
  output logic signed [SumOW-1:0]  sum_value_o,
  output logic [CntOW-1:0]         samples_held_o,
  output logic                     error_flag_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_data_i
);

  localparam int Entries = NUM_BITS * (NUM_BITS + 1) / 2;
  localparam int AW      = $clog2(Entries);
  localparam int IW      = $clog2(NUM_BITS);
  localparam int CntW    = $clog2(MAX_SAMPLES + 1);
  localparam int SumW    = CntW + 1;
  localparam int DvW     = CntW + FracW;
  localparam int DcW     = $clog2(DvW + 1);
  localparam int DiffW   = ModelW + 1;
  localparam int ProdW   = DiffW + CfgW + 1;
  localparam int StepW   = ProdW - FracW;
  localparam int NewW    = StepW + 1;

  localparam logic [3:0] ST_SWEEP = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_ADD   = 4'd2;
  localparam logic [3:0] ST_LRD   = 4'd3;
  localparam logic [3:0] ST_LLD   = 4'd4;
  localparam logic [3:0] ST_LDIV  = 4'd5;
  localparam logic [3:0] ST_LMUL  = 4'd6;
  localparam logic [3:0] ST_LWR   = 4'd7;
  localparam logic [3:0] ST_READ  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       sweep_model_q, sweep_model_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic       iss_done_q, iss_done_d;
  logic       p_vld_q, p_vld_d;
  logic [AW-1:0] p_addr_q, p_addr_d;
  logic       p_neg_q, p_neg_d;
  logic [NUM_BITS-1:0] bits_q, bits_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CfgW-1:0] rate_q, marg_q;
  logic       rd_ok_q, rd_ok_d;

  // learn datapath
  logic signed [ModelW-1:0] m_q, m_d;
  logic       neg_q, neg_d;
  logic [DvW-1:0] dvd_q, dvd_d;
  logic [CntW:0]  rem_q, rem_d;
  logic [DcW-1:0] dcnt_q, dcnt_d;
  logic signed [ProdW-1:0] prod_q, prod_d;

  // staged and output result
  logic signed [ModelW-1:0] res_m_q, res_m_d;
  logic signed [SumOW-1:0]  res_s_q, res_s_d;
  logic       res_e_q, res_e_d;
  logic       out_valid_q, out_valid_d;
  logic signed [ModelW-1:0] out_m_q, out_m_d;
  logic signed [SumOW-1:0]  out_s_q, out_s_d;
  logic [CntOW-1:0] out_c_q, out_c_d;
  logic       out_e_q, out_e_d;

  // memory ports
  logic          s_we, m_we;
  logic [AW-1:0] s_waddr, m_waddr, raddr;
  logic [SumW-1:0]   s_wdata, s_rdata;
  logic [ModelW-1:0] m_wdata, m_rdata;

  sml_ram #(.Width(SumW), .Depth(Entries)) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .raddr_i(raddr),
    .rdata_o(s_rdata)
  );

  sml_ram #(.Width(ModelW), .Depth(Entries)) u_model_ram (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(m_wdata),
    .raddr_i(raddr),
    .rdata_o(m_rdata)
  );

  // sample bits widened to NUM_BITS; variables past the field read 0
  logic [NUM_BITS-1:0] bits_in;
  for (genvar k = 0; k < NUM_BITS; k++) begin : g_bits
    if (k < SampW) begin : g_in
      assign bits_in[k] = sample_bits_i[k];
    end else begin : g_zero
      assign bits_in[k] = 1'b0;
    end
  end

  // read address of (row, col), folded onto the lower triangle
  logic [IdxW-1:0] hi_idx, lo_idx;
  logic            in_rng;
  logic [31:0]     tri_full;
  assign hi_idx   = (row_index_i >= col_index_i) ? row_index_i : col_index_i;
  assign lo_idx   = (row_index_i >= col_index_i) ? col_index_i : row_index_i;
  assign in_rng   = (32'(hi_idx) < 32'(NUM_BITS));
  assign tri_full = ((32'(hi_idx) * (32'(hi_idx) + 32'd1)) >> 1) + 32'(lo_idx);

  logic [CfgW-1:0] rate_eff, marg_eff;
  assign rate_eff = (rate_q > OneQ16) ? OneQ16 : rate_q;
  assign marg_eff = (marg_q > OneQ16) ? OneQ16 : marg_q;

  logic accept;
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // learn arithmetic
  logic [CntW:0]  rem_sh;
  logic           q_bit;
  logic signed [DiffW-1:0] avg, diff;
  logic signed [StepW-1:0] step;
  logic signed [NewW-1:0]  m_new, hi_lim, lo_lim;
  logic signed [ModelW-1:0] m_clip;
  logic [CntW-1:0] mag;
  logic signed [SumW-1:0] s_sig;
  logic signed [31:0] s_ext;

  assign s_sig  = $signed(s_rdata);
  assign mag    = s_sig[SumW-1] ? CntW'(-s_sig) : CntW'(s_sig);
  assign rem_sh = {rem_q[CntW-1:0], dvd_q[DvW-1]};
  assign q_bit  = (rem_sh >= {1'b0, cnt_q});
  assign avg    = neg_q ? -$signed({2'b00, dvd_q[FracW:0]})
                        :  $signed({2'b00, dvd_q[FracW:0]});
  assign diff   = avg - DiffW'(m_q);
  assign step   = prod_q[ProdW-1:FracW];
  assign m_new  = NewW'(m_q) + NewW'(step);
  assign hi_lim = $signed(NewW'(OneQ16)) - $signed(NewW'(marg_eff));
  assign lo_lim = -hi_lim;
  assign m_clip = (m_new > hi_lim) ? ModelW'(hi_lim)
                : (m_new < lo_lim) ? ModelW'(lo_lim) : ModelW'(m_new);
  assign s_ext  = 32'(s_sig);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    sweep_model_d = sweep_model_q;
    addr_d        = addr_q;
    i_d           = i_q;
    j_d           = j_q;
    iss_done_d    = iss_done_q;
    p_vld_d       = 1'b0;
    p_addr_d      = p_addr_q;
    p_neg_d       = p_neg_q;
    bits_d        = bits_q;
    cnt_d         = cnt_q;
    rd_ok_d       = rd_ok_q;
    m_d           = m_q;
    neg_d         = neg_q;
    dvd_d         = dvd_q;
    rem_d         = rem_q;
    dcnt_d        = dcnt_q;
    prod_d        = prod_q;
    res_m_d       = res_m_q;
    res_s_d       = res_s_q;
    res_e_d       = res_e_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_m_d       = out_m_q;
    out_s_d       = out_s_q;
    out_c_d       = out_c_q;
    out_e_d       = out_e_q;
    s_we          = 1'b0;
    s_waddr       = addr_q;
    s_wdata       = '0;
    m_we          = 1'b0;
    m_waddr       = addr_q;
    m_wdata       = '0;
    raddr         = addr_q;

    case (state_q)
      ST_SWEEP: begin
        s_we = 1'b1;
        m_we = sweep_model_q;
        addr_d = addr_q + AW'(1);
        if (addr_q == AW'(Entries - 1)) begin
          addr_d = '0;
          state_d = sweep_model_q ? ST_IDLE : ST_FIN;
          sweep_model_d = 1'b0;
        end
      end
      ST_IDLE: begin
        res_m_d = '0;
        res_s_d = '0;
        res_e_d = 1'b0;
        addr_d  = '0;
        i_d     = '0;
        j_d     = '0;
        iss_done_d = 1'b0;
        bits_d  = bits_in;
        if (accept) begin
          case (action_e'(action_i))
            ACT_CLEAR: begin
              cnt_d = '0;
              state_d = ST_SWEEP;
            end
            ACT_ADD: begin
              if (cnt_q >= CntW'(MAX_SAMPLES)) begin
                res_e_d = 1'b1;
                state_d = ST_FIN;
              end else begin
                cnt_d = cnt_q + CntW'(1);
                state_d = ST_ADD;
              end
            end
            ACT_LEARN: begin
              if (cnt_q == '0) begin
                res_e_d = 1'b1;
                state_d = ST_FIN;
              end else begin
                state_d = ST_LRD;
              end
            end
            ACT_READ: begin
              rd_ok_d = in_rng;
              raddr = in_rng ? AW'(tri_full) : '0;
              state_d = ST_READ;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        // issue reads in address order; write each back in the following cycle
        if (p_vld_q) begin
          s_we    = 1'b1;
          s_waddr = p_addr_q;
          s_wdata = p_neg_q ? s_rdata - SumW'(1) : s_rdata + SumW'(1);
        end
        if (!iss_done_q) begin
          raddr    = addr_q;
          p_vld_d  = 1'b1;
          p_addr_d = addr_q;
          p_neg_d  = (j_q == i_q) ? bits_q[i_q] : (bits_q[i_q] ^ bits_q[j_q]);
          addr_d   = addr_q + AW'(1);
          if (j_q == i_q) begin
            j_d = '0;
            i_d = i_q + IW'(1);
          end else begin
            j_d = j_q + IW'(1);
          end
          if (addr_q == AW'(Entries - 1)) begin
            iss_done_d = 1'b1;
          end
        end else if (!p_vld_q) begin
          state_d = ST_FIN;
        end
      end
      ST_LRD: begin
        raddr = addr_q;
        state_d = ST_LLD;
      end
      ST_LLD: begin
        m_d    = $signed(m_rdata);
        neg_d  = s_sig[SumW-1];
        dvd_d  = {mag, FracW'(0)};
        rem_d  = '0;
        dcnt_d = DcW'(DvW);
        state_d = ST_LDIV;
      end
      ST_LDIV: begin
        rem_d  = q_bit ? rem_sh - {1'b0, cnt_q} : rem_sh;
        dvd_d  = {dvd_q[DvW-2:0], q_bit};
        dcnt_d = dcnt_q - DcW'(1);
        if (dcnt_q == DcW'(1)) begin
          state_d = ST_LMUL;
        end
      end
      ST_LMUL: begin
        prod_d = ProdW'(diff) * $signed({2'b00, rate_eff});
        state_d = ST_LWR;
      end
      ST_LWR: begin
        m_we    = 1'b1;
        m_wdata = m_clip;
        addr_d  = addr_q + AW'(1);
        state_d = ST_LRD;
        if (addr_q == AW'(Entries - 1)) begin
          addr_d = '0;
          state_d = ST_FIN;
        end
      end
      ST_READ: begin
        res_m_d = rd_ok_q ? $signed(m_rdata) : '0;
        res_s_d = rd_ok_q ? s_ext[SumOW-1:0] : '0;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_m_d = res_m_q;
          out_s_d = res_s_q;
          out_c_d = CntOW'(32'(cnt_q));
          out_e_d = res_e_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      sweep_model_q <= 1'b1;
      addr_q        <= '0;
      i_q           <= '0;
      j_q           <= '0;
      iss_done_q    <= 1'b0;
      p_vld_q       <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      rate_q        <= RateRst;
      marg_q        <= MargRst;
    end else begin
      state_q       <= state_d;
      sweep_model_q <= sweep_model_d;
      addr_q        <= addr_d;
      i_q           <= i_d;
      j_q           <= j_d;
      iss_done_q    <= iss_done_d;
      p_vld_q       <= p_vld_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_LEARN_RATE) begin
          rate_q <= cfg_data_i;
        end else if (cfg_idx_i == REG_CLIP_MARGIN) begin
          marg_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_addr_q <= p_addr_d;
    p_neg_q  <= p_neg_d;
    bits_q   <= bits_d;
    rd_ok_q  <= rd_ok_d;
    m_q      <= m_d;
    neg_q    <= neg_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    dcnt_q   <= dcnt_d;
    prod_q   <= prod_d;
    res_m_q  <= res_m_d;
    res_s_q  <= res_s_d;
    res_e_q  <= res_e_d;
    out_m_q  <= out_m_d;
    out_s_q  <= out_s_d;
    out_c_q  <= out_c_d;
    out_e_q  <= out_e_d;
  end

  assign out_valid_o    = out_valid_q;
  assign model_value_o  = out_m_q;
  assign sum_value_o    = out_s_q;
  assign samples_held_o = out_c_q;
  assign error_flag_o   = out_e_q;

endmodule
